### src/c_subset_tokenizer_core_macros.svh
// Assertion macros for the tokenizer core checker.
// Used by c_subset_tokenizer_core_checker.sv only.
`ifndef C_SUBSET_TOKENIZER_CORE_MACROS_SVH
`define C_SUBSET_TOKENIZER_CORE_MACROS_SVH
// implication checked on every clock, idle in reset
`define CST_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tokenizer check failed");
// next-cycle implication
`define CST_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tokenizer check failed");
`endif

### src/cst_pkg.sv
// Package for the C subset tokenizer: field widths, codes and kind tables.
// No dependencies.
`default_nettype none
package cst_pkg;
    localparam int LINE_BITS   = 16;
    localparam int COLUMN_BITS = 16;
    localparam int OFFSET_BITS = 24;
    localparam int LENGTH_BITS = 8;

    typedef enum logic [2:0] {
        MODE_IDLE, MODE_NUMBER, MODE_WORD, MODE_OPERATOR,
        MODE_LINE_COMMENT, MODE_BLOCK_COMMENT, MODE_ERROR
    } mode_t;

    typedef enum logic [3:0] {
        OP_NONE, OP_BANG, OP_EQ, OP_LT, OP_GT, OP_PLUS, OP_MINUS,
        OP_STAR, OP_SLASH, OP_AMP, OP_BAR
    } op_t;

    localparam logic [5:0] KIND_LITERAL = 6'd0;
    localparam logic [5:0] KIND_IDENT   = 6'd1;
    localparam logic [5:0] KIND_INT     = 6'd2;
    localparam logic [5:0] KIND_RETURN  = 6'd3;
    localparam logic [5:0] KIND_IF      = 6'd4;
    localparam logic [5:0] KIND_ELSE    = 6'd5;
    localparam logic [5:0] KIND_WHILE   = 6'd6;
    localparam logic [5:0] KIND_FOR     = 6'd7;
    localparam logic [5:0] KIND_MOD     = 6'd12;
    localparam logic [5:0] KIND_ANDAND  = 6'd19;
    localparam logic [5:0] KIND_OROR    = 6'd20;
    localparam logic [5:0] KIND_LPAREN  = 6'd27;
    localparam logic [5:0] KIND_RPAREN  = 6'd28;
    localparam logic [5:0] KIND_LBRACE  = 6'd29;
    localparam logic [5:0] KIND_RBRACE  = 6'd30;
    localparam logic [5:0] KIND_SEMI    = 6'd31;
    localparam logic [5:0] KIND_COMMA   = 6'd32;
    localparam logic [5:0] KIND_END     = 6'd33;

    localparam logic [2:0] ERR_NONE   = 3'd0;
    localparam logic [2:0] ERR_OPEN   = 3'd1;
    localparam logic [2:0] ERR_AMP    = 3'd2;
    localparam logic [2:0] ERR_BAR    = 3'd3;
    localparam logic [2:0] ERR_STRAY  = 3'd4;

    typedef struct packed {
        logic [5:0]             kind;
        logic [LINE_BITS-1:0]   line;
        logic [COLUMN_BITS-1:0] column;
        logic [OFFSET_BITS-1:0] offset;
        logic [LENGTH_BITS-1:0] length;
        logic [2:0]             err;
        logic                   last;
    } token_t;

    // single-character kind of a pending operator
    function automatic logic [5:0] op_single(op_t op);
        case (op)
            OP_BANG:  return 6'd21;
            OP_EQ:    return 6'd22;
            OP_LT:    return 6'd15;
            OP_GT:    return 6'd17;
            OP_PLUS:  return 6'd8;
            OP_MINUS: return 6'd9;
            OP_STAR:  return 6'd10;
            OP_SLASH: return 6'd11;
            default:  return 6'd0;
        endcase
    endfunction

    // kind of a pending operator followed by '='
    function automatic logic [5:0] op_with_eq(op_t op);
        case (op)
            OP_BANG:  return 6'd14;
            OP_EQ:    return 6'd13;
            OP_LT:    return 6'd16;
            OP_GT:    return 6'd18;
            OP_PLUS:  return 6'd23;
            OP_MINUS: return 6'd24;
            OP_STAR:  return 6'd25;
            OP_SLASH: return 6'd26;
            default:  return 6'd0;
        endcase
    endfunction

    // operator that a byte opens
    function automatic op_t op_of(logic [7:0] c);
        case (c)
            8'h21:   return OP_BANG;
            8'h3d:   return OP_EQ;
            8'h3c:   return OP_LT;
            8'h3e:   return OP_GT;
            8'h2b:   return OP_PLUS;
            8'h2d:   return OP_MINUS;
            8'h2a:   return OP_STAR;
            8'h2f:   return OP_SLASH;
            8'h26:   return OP_AMP;
            8'h7c:   return OP_BAR;
            default: return OP_NONE;
        endcase
    endfunction

    // punctuation kind, 0 when the byte is not punctuation
    function automatic logic [5:0] punct_of(logic [7:0] c);
        case (c)
            8'h28:   return KIND_LPAREN;
            8'h29:   return KIND_RPAREN;
            8'h7b:   return KIND_LBRACE;
            8'h7d:   return KIND_RBRACE;
            8'h3b:   return KIND_SEMI;
            8'h2c:   return KIND_COMMA;
            8'h25:   return KIND_MOD;
            default: return 6'd0;
        endcase
    endfunction
endpackage
`default_nettype wire

### src/cst_stream_if.sv
// Valid/ready stream interface carrying one payload beat.
// Depends on nothing; payload type set by the instantiating scope.
`default_nettype none
interface cst_stream_if #(parameter type payload_t = logic [8:0]);
    logic     valid;
    logic     ready;
    payload_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

### src/c_subset_tokenizer_core.sv
// C subset tokenizer core: byte stream in, token stream out.
// Depends on cst_pkg and cst_stream_if.
//
// Use: text_in carries one byte per beat (payload {end_of_text, text_byte}).
// token_out carries token_t beats; last is set on the final token caused by
// a byte. A byte causes zero, one or two tokens.
// A byte's tokens are written into the four-entry output queue when the
// byte is accepted; token_out shows the head of the queue. Throughput: one
// byte per cycle when bytes cause at most one token and the receiver does
// not stall; a byte causing two tokens fills two queue slots.
// A byte is accepted while the output queue has room for two tokens; when
// the receiver stalls, tokens hold in the queue and input stops once fewer
// than two slots are free.
// Reset clears the scanner to start of text (line 1, column 1, offset 0)
// and empties the queue. An end marker flushes, emits the end token and
// returns the scanner to that same state.
`default_nettype none
module c_subset_tokenizer_core (
    input  wire   clk,
    input  wire   rst_n,
    cst_stream_if.sink   text_in,
    cst_stream_if.source token_out
);
    import cst_pkg::*;

    mode_t                  mode_reg, mode_next;
    op_t                    pop_reg, pop_next;
    logic [LINE_BITS-1:0]   line_reg, line_next, sline_reg, sline_next;
    logic [COLUMN_BITS-1:0] col_reg, col_next, scol_reg, scol_next;
    logic [OFFSET_BITS-1:0] off_reg, off_next, soff_reg, soff_next;
    logic [LENGTH_BITS-1:0] len_reg, len_next;
    logic [47:0]            pre_reg, pre_next;
    logic                   star_reg, star_next;

    // four-entry output queue
    token_t     q_reg [4];
    logic [1:0] rd_reg, wr_reg;
    logic [2:0] cnt_reg;

    logic [7:0] c;
    logic       eot, fire;
    token_t     r0, r1;
    logic [1:0] n;

    assign c   = text_in.payload[7:0];
    assign eot = text_in.payload[8];
    assign text_in.ready = (cnt_reg <= 3'd2);
    assign fire = text_in.valid && text_in.ready;
    assign token_out.valid   = (cnt_reg != 3'd0);
    assign token_out.payload = q_reg[rd_reg];

    function automatic logic is_digit(logic [7:0] b);
        return b >= 8'h30 && b <= 8'h39;
    endfunction
    function automatic logic is_alpha(logic [7:0] b);
        return (b >= 8'h61 && b <= 8'h7a) || (b >= 8'h41 && b <= 8'h5a) || b == 8'h5f;
    endfunction

    // keyword lookup on length and stored prefix
    function automatic logic [5:0] word_kind(logic [LENGTH_BITS-1:0] l, logic [47:0] p);
        if (l == LENGTH_BITS'(3) && p == 48'h696e74) return KIND_INT;
        if (l == LENGTH_BITS'(6) && p == 48'h72657475726e) return KIND_RETURN;
        if (l == LENGTH_BITS'(2) && p == 48'h6966) return KIND_IF;
        if (l == LENGTH_BITS'(4) && p == 48'h656c7365) return KIND_ELSE;
        if (l == LENGTH_BITS'(5) && p == 48'h7768696c65) return KIND_WHILE;
        if (l == LENGTH_BITS'(3) && p == 48'h666f72) return KIND_FOR;
        return KIND_IDENT;
    endfunction

    function automatic token_t mk(logic [5:0] k, logic [LINE_BITS-1:0] ln,
        logic [COLUMN_BITS-1:0] cl, logic [OFFSET_BITS-1:0] of,
        logic [LENGTH_BITS-1:0] le, logic [2:0] e);
        token_t t;
        t.kind = k; t.line = ln; t.column = cl; t.offset = of;
        t.length = le; t.err = e; t.last = 1'b0;
        return t;
    endfunction

    // scanner next state and produced tokens
    always_comb
    begin
        token_t t;
        logic fresh, adv;
        logic [LINE_BITS-1:0]   lnx;
        logic [COLUMN_BITS-1:0] clx;
        logic [OFFSET_BITS-1:0] ofx;
        mode_next = mode_reg; pop_next = pop_reg;
        line_next = line_reg; col_next = col_reg; off_next = off_reg;
        sline_next = sline_reg; scol_next = scol_reg; soff_next = soff_reg;
        len_next = len_reg; pre_next = pre_reg; star_next = star_reg;
        r0 = '0; r1 = '0; n = 2'd0; fresh = 1'b0; adv = 1'b0; t = '0;
        lnx = line_reg; clx = col_reg; ofx = off_reg;
        if (eot) begin
            case (mode_reg)
                MODE_NUMBER: begin t = mk(KIND_LITERAL, sline_reg, scol_reg, soff_reg,
                    len_reg, ERR_NONE); r0 = t; n = 2'd1; end
                MODE_WORD: begin t = mk(word_kind(len_reg, pre_reg), sline_reg, scol_reg,
                    soff_reg, len_reg, ERR_NONE); r0 = t; n = 2'd1; end
                MODE_OPERATOR:
                begin
                    if (pop_reg == OP_AMP || pop_reg == OP_BAR) begin
                        r0 = mk(6'd0, sline_reg, scol_reg, soff_reg, '0,
                            pop_reg == OP_AMP ? ERR_AMP : ERR_BAR); n = 2'd1;
                    end else if (pop_reg != OP_NONE) begin
                        r0 = mk(op_single(pop_reg), sline_reg, scol_reg, soff_reg,
                            LENGTH_BITS'(1), ERR_NONE); n = 2'd1;
                    end
                end
                MODE_BLOCK_COMMENT: begin r0 = mk(6'd0, line_reg, col_reg, off_reg, '0,
                    ERR_OPEN); n = 2'd1; end
                default: ;
            endcase
            t = mk(KIND_END, line_reg, col_reg, off_reg, '0, ERR_NONE);
            if (n == 2'd0) r0 = t; else r1 = t;
            n = n + 2'd1;
            mode_next = MODE_IDLE; pop_next = OP_NONE;
            line_next = LINE_BITS'(1); col_next = COLUMN_BITS'(1); off_next = '0;
            sline_next = LINE_BITS'(1); scol_next = COLUMN_BITS'(1); soff_next = '0;
            len_next = '0; pre_next = '0; star_next = 1'b0;
        end else begin
            case (mode_reg)
                MODE_NUMBER, MODE_WORD:
                begin
                    if (is_digit(c) || (mode_reg == MODE_WORD && is_alpha(c))) begin
                        if (len_reg < LENGTH_BITS'(6)) pre_next = {pre_reg[39:0], c};
                        if (len_reg != '1) len_next = len_reg + LENGTH_BITS'(1);
                        adv = 1'b1;
                    end else begin
                        r0 = mk(mode_reg == MODE_WORD ? word_kind(len_reg, pre_reg)
                            : KIND_LITERAL, sline_reg, scol_reg, soff_reg, len_reg,
                            ERR_NONE);
                        n = 2'd1; fresh = 1'b1;
                    end
                end
                MODE_OPERATOR:
                begin
                    pop_next = OP_NONE;
                    if (pop_reg == OP_SLASH && c == 8'h2f) begin
                        mode_next = MODE_LINE_COMMENT; adv = 1'b1;
                    end else if (pop_reg == OP_SLASH && c == 8'h2a) begin
                        mode_next = MODE_BLOCK_COMMENT; star_next = 1'b0; adv = 1'b1;
                    end else if ((pop_reg == OP_AMP && c == 8'h26)
                        || (pop_reg == OP_BAR && c == 8'h7c)) begin
                        r0 = mk(pop_reg == OP_AMP ? KIND_ANDAND : KIND_OROR, sline_reg,
                            scol_reg, soff_reg, LENGTH_BITS'(2), ERR_NONE);
                        n = 2'd1; mode_next = MODE_IDLE; adv = 1'b1;
                    end else if (pop_reg == OP_AMP || pop_reg == OP_BAR) begin
                        r0 = mk(6'd0, sline_reg, scol_reg, soff_reg, '0,
                            pop_reg == OP_AMP ? ERR_AMP : ERR_BAR);
                        n = 2'd1; mode_next = MODE_ERROR;
                    end else if (pop_reg != OP_NONE && c == 8'h3d) begin
                        r0 = mk(op_with_eq(pop_reg), sline_reg, scol_reg, soff_reg,
                            LENGTH_BITS'(2), ERR_NONE);
                        n = 2'd1; mode_next = MODE_IDLE; adv = 1'b1;
                    end else begin
                        if (pop_reg != OP_NONE) begin
                            r0 = mk(op_single(pop_reg), sline_reg, scol_reg, soff_reg,
                                LENGTH_BITS'(1), ERR_NONE);
                            n = 2'd1;
                        end
                        fresh = 1'b1;
                    end
                end
                MODE_LINE_COMMENT:
                begin
                    adv = 1'b1;
                    if (c == 8'h0a) mode_next = MODE_IDLE;
                end
                MODE_BLOCK_COMMENT:
                begin
                    adv = 1'b1;
                    if (star_reg && c == 8'h2f) begin
                        mode_next = MODE_IDLE; star_next = 1'b0;
                    end else begin
                        star_next = (c == 8'h2a);
                    end
                end
                MODE_ERROR: ;
                default: fresh = 1'b1;
            endcase
            // start a new token from idle
            if (fresh) begin
                mode_next = MODE_IDLE;
                if (c == 8'h20 || (c >= 8'h09 && c <= 8'h0d)) begin
                    adv = 1'b1;
                end else if (is_digit(c) || is_alpha(c)) begin
                    sline_next = line_reg; scol_next = col_reg; soff_next = off_reg;
                    pre_next = {40'd0, c}; len_next = LENGTH_BITS'(1);
                    mode_next = is_digit(c) ? MODE_NUMBER : MODE_WORD; adv = 1'b1;
                end else if (op_of(c) != OP_NONE) begin
                    sline_next = line_reg; scol_next = col_reg; soff_next = off_reg;
                    pop_next = op_of(c); mode_next = MODE_OPERATOR; adv = 1'b1;
                end else begin
                    if (punct_of(c) != 6'd0) begin
                        t = mk(punct_of(c), line_reg, col_reg, off_reg, LENGTH_BITS'(1),
                            ERR_NONE);
                        adv = 1'b1;
                    end else begin
                        t = mk(6'd0, line_reg, col_reg, off_reg, '0, ERR_STRAY);
                        mode_next = MODE_ERROR;
                    end
                    if (n == 2'd0) r0 = t; else r1 = t;
                    n = n + 2'd1;
                end
            end
            // advance position counters
            if (adv) begin
                if (c == 8'h0a) begin
                    if (line_reg != '1) lnx = line_reg + LINE_BITS'(1);
                    clx = COLUMN_BITS'(1);
                end else if (col_reg != '1) begin
                    clx = col_reg + COLUMN_BITS'(1);
                end
                if (off_reg != '1) ofx = off_reg + OFFSET_BITS'(1);
                line_next = lnx; col_next = clx; off_next = ofx;
            end
        end
        if (n == 2'd1) r0.last = 1'b1;
        if (n == 2'd2) r1.last = 1'b1;
    end

    // scanner state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg <= MODE_IDLE; pop_reg <= OP_NONE;
            line_reg <= LINE_BITS'(1); col_reg <= COLUMN_BITS'(1); off_reg <= '0;
            sline_reg <= LINE_BITS'(1); scol_reg <= COLUMN_BITS'(1); soff_reg <= '0;
            len_reg <= '0; pre_reg <= '0; star_reg <= 1'b0;
        end else if (fire) begin
            mode_reg <= mode_next; pop_reg <= pop_next;
            line_reg <= line_next; col_reg <= col_next; off_reg <= off_next;
            sline_reg <= sline_next; scol_reg <= scol_next; soff_reg <= soff_next;
            len_reg <= len_next; pre_reg <= pre_next; star_reg <= star_next;
        end
    end

    // queue payload writes
    always_ff @(posedge clk)
    begin
        if (fire && n != 2'd0) q_reg[wr_reg] <= r0;
        if (fire && n == 2'd2) q_reg[wr_reg + 2'd1] <= r1;
    end

    // queue pointers and fill
    always_ff @(posedge clk or negedge rst_n)
    begin
        logic pop;
        logic [1:0] push;
        if (!rst_n) begin
            rd_reg <= '0; wr_reg <= '0; cnt_reg <= '0;
        end else begin
            pop  = token_out.valid && token_out.ready;
            push = fire ? n : 2'd0;
            wr_reg  <= wr_reg + push;
            rd_reg  <= rd_reg + {1'b0, pop};
            cnt_reg <= cnt_reg + {1'b0, push} - {2'b0, pop};
        end
    end
endmodule
`default_nettype wire

### src/c_subset_tokenizer_core_checker.sv
// Port-level checker for the tokenizer core, bound into c_subset_tokenizer_core.
// Depends on cst_pkg and the macros header.
`default_nettype none
`include "c_subset_tokenizer_core_macros.svh"
module c_subset_tokenizer_core_checker (
    input wire                   clk,
    input wire                   rst_n,
    input wire                   in_valid,
    input wire                   in_ready,
    input wire [8:0]             in_payload,
    input wire                   out_valid,
    input wire                   out_ready,
    input wire cst_pkg::token_t  out_payload
);
    import cst_pkg::*;
    `CST_ASSERT_NXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_payload))
    `CST_ASSERT_NXT(a_result, clk, rst_n, in_valid && in_ready && in_payload[8], out_valid)
    `CST_ASSERT_IMP(a_err_nokind, clk, rst_n, out_valid && out_payload.err != ERR_NONE, out_payload.kind == 6'd0 && out_payload.length == '0)
    `CST_ASSERT_IMP(a_end_last, clk, rst_n, out_valid && out_payload.kind == KIND_END, out_payload.last)
endmodule

bind c_subset_tokenizer_core c_subset_tokenizer_core_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(text_in.valid), .in_ready(text_in.ready), .in_payload(text_in.payload),
    .out_valid(token_out.valid), .out_ready(token_out.ready),
    .out_payload(token_out.payload)
);
`default_nettype wire

### tb/c_subset_tokenizer_core_tb.sv
// Testbench for the C subset tokenizer core: drives byte beats, predicts tokens.
// Depends on cst_pkg, cst_stream_if and c_subset_tokenizer_core.
`timescale 1ns / 1ps
`default_nettype none
module c_subset_tokenizer_core_tb;
    import cst_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int STALL_CYCLES   = 300;

    logic clk;
    logic rst_n;

    cst_stream_if #(.payload_t(logic [8:0])) text_in ();
    cst_stream_if #(.payload_t(token_t))     token_out ();

    c_subset_tokenizer_core dut (
        .clk(clk),
        .rst_n(rst_n),
        .text_in(text_in.sink),
        .token_out(token_out.source)
    );

    // Clock
    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // Predictor state
    mode_t       lex_mode;
    op_t         lex_op;
    logic [15:0] cur_line, cur_col, tok_line, tok_col;
    logic [23:0] cur_off, tok_off;
    logic [7:0]  tok_len;
    logic [47:0] tok_prefix;
    logic        star_seen;

    token_t      expected_tokens[$];
    logic [8:0]  pending_bytes[$];
    token_t      step_out[$];

    int          fail_count;
    int          idle_count;
    int          stall_hold;

    task automatic lexer_reset();
        lex_mode = MODE_IDLE;
        lex_op = OP_NONE;
        cur_line = 16'd1;
        cur_col = 16'd1;
        cur_off = 24'd0;
        tok_line = 16'd1;
        tok_col = 16'd1;
        tok_off = 24'd0;
        tok_len = 8'd0;
        tok_prefix = 48'd0;
        star_seen = 1'b0;
    endtask

    function automatic bit is_digit(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit is_alpha(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction

    function automatic bit is_space(logic [7:0] c);
        return c == " " || (c >= 8'd9 && c <= 8'd13);
    endfunction

    task automatic push_token(logic [5:0] kind, logic [15:0] ln, logic [15:0] col,
                              logic [23:0] off, logic [7:0] len, logic [2:0] err);
        token_t t;
        t.kind = kind;
        t.line = ln;
        t.column = col;
        t.offset = off;
        t.length = len;
        t.err = err;
        t.last = 1'b0;
        step_out.push_back(t);
    endtask

    task automatic step_position(logic [7:0] c);
        if (c == 8'h0a)
        begin
            if (cur_line != 16'hffff)
                cur_line++;
            cur_col = 16'd1;
        end
        else if (cur_col != 16'hffff)
            cur_col++;
        if (cur_off != 24'hffffff)
            cur_off++;
    endtask

    task automatic grow_word(logic [7:0] c);
        if (tok_len < 8'd6)
            tok_prefix = {tok_prefix[39:0], c};
        if (tok_len != 8'hff)
            tok_len++;
        step_position(c);
    endtask

    function automatic logic [5:0] word_kind_of();
        case (tok_len)
            8'd2: if (tok_prefix == 48'h6966) return KIND_IF;
            8'd3:
            begin
                if (tok_prefix == 48'h696e74) return KIND_INT;
                if (tok_prefix == 48'h666f72) return KIND_FOR;
            end
            8'd4: if (tok_prefix == 48'h656c7365) return KIND_ELSE;
            8'd5: if (tok_prefix == 48'h7768696c65) return KIND_WHILE;
            8'd6: if (tok_prefix == 48'h72657475726e) return KIND_RETURN;
            default: ;
        endcase
        return KIND_IDENT;
    endfunction

    task automatic start_from_idle(logic [7:0] c);
        op_t        o;
        logic [5:0] p;
        o = op_of(c);
        p = punct_of(c);
        lex_mode = MODE_IDLE;
        if (is_space(c))
            step_position(c);
        else if (is_digit(c) || is_alpha(c))
        begin
            tok_line = cur_line;
            tok_col = cur_col;
            tok_off = cur_off;
            tok_len = 8'd0;
            tok_prefix = 48'd0;
            lex_mode = is_digit(c) ? MODE_NUMBER : MODE_WORD;
            grow_word(c);
        end
        else if (o != OP_NONE)
        begin
            tok_line = cur_line;
            tok_col = cur_col;
            tok_off = cur_off;
            lex_op = o;
            lex_mode = MODE_OPERATOR;
            step_position(c);
        end
        else if (p != 6'd0)
        begin
            push_token(p, cur_line, cur_col, cur_off, 8'd1, ERR_NONE);
            step_position(c);
        end
        else
        begin
            push_token(KIND_LITERAL, cur_line, cur_col, cur_off, 8'd0, ERR_STRAY);
            lex_mode = MODE_ERROR;
        end
    endtask

    // Work out the tokens one byte beat causes
    task automatic predict_tokens(logic [8:0] beat);
        logic [7:0] c;
        op_t        o;
        bit         fresh;
        c = beat[7:0];
        o = lex_op;
        fresh = 1'b0;
        step_out.delete();
        if (beat[8])
        begin
            case (lex_mode)
                MODE_NUMBER:
                    push_token(KIND_LITERAL, tok_line, tok_col, tok_off, tok_len, ERR_NONE);
                MODE_WORD:
                    push_token(word_kind_of(), tok_line, tok_col, tok_off, tok_len, ERR_NONE);
                MODE_OPERATOR:
                    if (o == OP_AMP || o == OP_BAR)
                        push_token(KIND_LITERAL, tok_line, tok_col, tok_off, 8'd0,
                                   o == OP_AMP ? ERR_AMP : ERR_BAR);
                    else if (o != OP_NONE)
                        push_token(op_single(o), tok_line, tok_col, tok_off, 8'd1, ERR_NONE);
                MODE_BLOCK_COMMENT:
                    push_token(KIND_LITERAL, cur_line, cur_col, cur_off, 8'd0, ERR_OPEN);
                default: ;
            endcase
            push_token(KIND_END, cur_line, cur_col, cur_off, 8'd0, ERR_NONE);
            lexer_reset();
        end
        else
        begin
            case (lex_mode)
                MODE_NUMBER:
                    if (is_digit(c))
                        grow_word(c);
                    else
                    begin
                        push_token(KIND_LITERAL, tok_line, tok_col, tok_off, tok_len,
                                   ERR_NONE);
                        fresh = 1'b1;
                    end
                MODE_WORD:
                    if (is_digit(c) || is_alpha(c))
                        grow_word(c);
                    else
                    begin
                        push_token(word_kind_of(), tok_line, tok_col, tok_off, tok_len,
                                   ERR_NONE);
                        fresh = 1'b1;
                    end
                MODE_OPERATOR:
                begin
                    lex_op = OP_NONE;
                    if (o == OP_SLASH && c == "/")
                    begin
                        lex_mode = MODE_LINE_COMMENT;
                        step_position(c);
                    end
                    else if (o == OP_SLASH && c == "*")
                    begin
                        lex_mode = MODE_BLOCK_COMMENT;
                        star_seen = 1'b0;
                        step_position(c);
                    end
                    else if ((o == OP_AMP && c == "&") || (o == OP_BAR && c == "|"))
                    begin
                        push_token(o == OP_AMP ? KIND_ANDAND : KIND_OROR, tok_line, tok_col,
                                   tok_off, 8'd2, ERR_NONE);
                        lex_mode = MODE_IDLE;
                        step_position(c);
                    end
                    else if (o == OP_AMP || o == OP_BAR)
                    begin
                        push_token(KIND_LITERAL, tok_line, tok_col, tok_off, 8'd0,
                                   o == OP_AMP ? ERR_AMP : ERR_BAR);
                        lex_mode = MODE_ERROR;
                    end
                    else if (o != OP_NONE && c == "=")
                    begin
                        push_token(op_with_eq(o), tok_line, tok_col, tok_off, 8'd2, ERR_NONE);
                        lex_mode = MODE_IDLE;
                        step_position(c);
                    end
                    else
                    begin
                        if (o != OP_NONE)
                            push_token(op_single(o), tok_line, tok_col, tok_off, 8'd1,
                                       ERR_NONE);
                        fresh = 1'b1;
                    end
                end
                MODE_LINE_COMMENT:
                begin
                    step_position(c);
                    if (c == 8'h0a)
                        lex_mode = MODE_IDLE;
                end
                MODE_BLOCK_COMMENT:
                begin
                    step_position(c);
                    if (star_seen && c == "/")
                    begin
                        lex_mode = MODE_IDLE;
                        star_seen = 1'b0;
                    end
                    else
                        star_seen = (c == "*");
                end
                MODE_ERROR: ;
                default: fresh = 1'b1;
            endcase
            if (fresh)
                start_from_idle(c);
        end
        if (step_out.size() > 0)
            step_out[step_out.size() - 1].last = 1'b1;
        foreach (step_out[i])
            expected_tokens.push_back(step_out[i]);
    endtask

    // Stimulus builders
    task automatic add_byte(logic [7:0] c);
        pending_bytes.push_back({1'b0, c});
    endtask

    task automatic add_text(string s);
        for (int i = 0; i < s.len(); i++)
            add_byte(s[i]);
    endtask

    task automatic add_end();
        pending_bytes.push_back({1'b1, 8'($urandom)});
    endtask

    // Random lexeme with random content, or now and then a random noise byte
    task automatic add_random_lexeme();
        string words[12];
        string punct_set;
        string space_set;
        string op_set;
        string pair_set;
        int    n;
        words = '{"int", "return", "if", "else", "while", "for", "x_1", "returns",
                  "whil", "==", "&&", "||"};
        punct_set = " !=<>+-*/&|(){};,%";
        space_set = "\n\t \r\v\f";
        op_set = "!=<>+-*/";
        pair_set = "=&|";
        case ($urandom_range(0, 9))
            0: add_text(words[$urandom_range(0, 11)]);
            1:
            begin
                n = $urandom_range(1, 8);
                for (int i = 0; i < n; i++)
                    add_byte(8'($urandom_range("0", "9")));
            end
            2:
            begin
                n = $urandom_range(1, 9);
                add_byte(8'($urandom_range("a", "z")));
                for (int i = 1; i < n; i++)
                    add_byte(($urandom_range(0, 3) == 0) ? 8'($urandom_range("0", "9"))
                                                          : 8'($urandom_range("A", "Z")));
            end
            3: add_byte(punct_set[$urandom_range(0, 17)]);
            4: add_byte(space_set[$urandom_range(0, 5)]);
            5: add_text("/* a*b **/");
            6: add_text("// note\n");
            7: add_byte(op_set[$urandom_range(0, 7)]);
            8: add_byte(pair_set[$urandom_range(0, 2)]);
            default: add_byte(8'($urandom));
        endcase
    endtask

    // Driver: offer pending beats, idling at random
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            text_in.valid <= 1'b0;
            text_in.payload <= 9'd0;
        end
        else
        begin
            if (text_in.valid && text_in.ready)
                predict_tokens(text_in.payload);
            if (!(text_in.valid && !text_in.ready))
            begin
                if (text_in.valid && text_in.ready)
                    void'(pending_bytes.pop_front());
                if (pending_bytes.size() > 0 && ($urandom_range(0, 99) >= 10 ||
                    ($time / 1000) % 40 < 8))
                begin
                    text_in.valid <= 1'b1;
                    text_in.payload <= pending_bytes[0];
                end
                else
                    text_in.valid <= 1'b0;
            end
        end
    end

    // Long receiver hold-off right after reset, counted down here
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stall_hold <= STALL_CYCLES;
        else if (stall_hold > 0)
            stall_hold <= stall_hold - 1;
    end

    // Monitor: check each token beat against the oldest expectation
    always @(posedge clk or negedge rst_n)
    begin
        token_t exp_tok;
        if (!rst_n)
        begin
            token_out.ready <= 1'b0;
            idle_count <= 0;
        end
        else
        begin
            if ((text_in.valid && text_in.ready) || (token_out.valid && token_out.ready))
                idle_count <= 0;
            else
                idle_count <= idle_count + 1;
            if (token_out.valid && token_out.ready)
            begin
                if (expected_tokens.size() == 0)
                begin
                    $display("%0t: unexpected token expected none actual %p", $time,
                             token_out.payload);
                    fail_count++;
                end
                else
                begin
                    exp_tok = expected_tokens.pop_front();
                    if (exp_tok != token_out.payload)
                    begin
                        $display("%0t: token mismatch expected %p actual %p", $time,
                                 exp_tok, token_out.payload);
                        fail_count++;
                    end
                end
            end
            // Hold off during the long stretch, otherwise stall at random
            if (stall_hold > 0)
                token_out.ready <= 1'b0;
            else
                token_out.ready <= ($urandom_range(0, 99) >= 10 || ($time / 1000) % 40 < 8);
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        if (idle_count >= WATCHDOG_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin
        fail_count = 0;
        lexer_reset();
        text_in.valid = 1'b0;
        text_in.payload = 9'd0;
        token_out.ready = 1'b0;
        rst_n = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: keywords, near-keywords, operators, comments, errors
        add_text("int return if else while for returnx 0 255 _Az9\n");
        add_text("a+=b-=c*=d/=e==f!=g<=h>=i&&j||k!l<m>n%(x){y};z,q=1/2*3-4+5");
        add_end();
        add_text("/* open * comment");
        add_end();
        add_text("a & b");
        add_text("zz");
        add_end();
        add_text("x|");
        add_end();
        add_byte(8'h00);
        add_end();
        add_byte(8'hff);
        add_byte(8'h7f);
        add_end();
        add_text("// line\nabc");
        add_end();
        add_end();

        // Random: mostly well-formed lexemes, sometimes ended, sometimes noise
        while (pending_bytes.size() < 400)
        begin
            add_random_lexeme();
            if ($urandom_range(0, 29) == 0)
                add_end();
        end
        add_end();

        while (pending_bytes.size() != 0 || text_in.valid || expected_tokens.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (fail_count == 0 && expected_tokens.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
`default_nettype wire

### c_subset_tokenizer_core.f
+incdir+src
src/cst_pkg.sv
src/cst_stream_if.sv
src/c_subset_tokenizer_core.sv
src/c_subset_tokenizer_core_checker.sv
tb/c_subset_tokenizer_core_tb.sv
